// File: hdl/gve_pkg.sv
package gve_pkg;

  // Kind of value carried by an input request
  typedef enum logic [1:0] {
    OP_UNSIGNED = 2'd0,
    OP_SIGNED   = 2'd1,
    OP_DOUBLE   = 2'd2
  } op_e;

  // Masks for the byte-reversal network
  localparam logic [63:0] SWAP8_MASK  = 64'h00ff00ff00ff00ff;
  localparam logic [63:0] SWAP16_MASK = 64'h0000ffff0000ffff;

  // Largest word sent as a single byte
  localparam logic [63:0] SMALL_MAX   = 64'h7f;

  // Count byte is this base minus the number of data bytes
  localparam logic [8:0]  CNT_BASE    = 9'd256;

  // Queue geometry
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        is_single;
  } job_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

// File: hdl/gve_front.sv
module gve_front (
  input  gve_pkg::in_t  in_i,
  output gve_pkg::job_t job_o
);

  logic [63:0] sw8;
  logic [63:0] sw16;
  logic [63:0] reversed;
  logic [63:0] mapped;
  logic [63:0] word;
  logic [3:0]  nbytes;

  // Byte-reverse a double bit pattern
  assign sw8      = ((in_i.value >> 8) & gve_pkg::SWAP8_MASK)
                  | ((in_i.value & gve_pkg::SWAP8_MASK) << 8);
  assign sw16     = ((sw8 >> 16) & gve_pkg::SWAP16_MASK)
                  | ((sw8 & gve_pkg::SWAP16_MASK) << 16);
  assign reversed = {sw16[31:0], sw16[63:32]};

  // Fold a signed value so that the sign lands in bit 0
  assign mapped = in_i.value[63] ? {~in_i.value[62:0], 1'b1}
                                 : {in_i.value[62:0], 1'b0};

  // Select the word by kind; the unused kind reads as unsigned
  always_comb begin
    case (in_i.operation)
      gve_pkg::OP_SIGNED: word = mapped;
      gve_pkg::OP_DOUBLE: word = reversed;
      default:            word = in_i.value;
    endcase
  end

  // Count significant bytes
  always_comb begin
    nbytes = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (word[8*k +: 8] != 8'd0) begin
        nbytes = 4'(k + 1);
      end
    end
  end

  assign job_o.word      = word;
  assign job_o.nbytes    = nbytes;
  assign job_o.is_single = (word <= gve_pkg::SMALL_MAX);

endmodule

// File: hdl/gve_queue.sv
module gve_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gve_pkg::job_t    job_i,
  input  logic             pop_i,
  output gve_pkg::job_t    job_o,
  output gve_pkg::qstat_t  stat_o
);

  gve_pkg::job_t                  mem_q [gve_pkg::QDEPTH];
  logic [gve_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [gve_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [gve_pkg::QPTR_W:0]       count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (gve_pkg::QPTR_W + 1)'(gve_pkg::QDEPTH));
  assign job_o        = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: hdl/gve_back.sv
module gve_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gve_pkg::job_t    job_i,
  input  gve_pkg::qstat_t  stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gve_pkg::out_t    out_o
);

  logic          busy_q, busy_d;
  logic [63:0]   word_q, word_d;
  logic [2:0]    idx_q, idx_d;
  logic          oval_q, oval_d;
  gve_pkg::out_t out_q, out_d;
  logic          load;

  // Output register may take a new byte when empty or being drained
  assign load  = !oval_q || out_ready_i;
  assign pop_o = load && !busy_q && !stat_i.empty;

  // Serialise: a small word as one byte, else count byte first, then data bytes most significant first
  always_comb begin
    busy_d = busy_q;
    word_d = word_q;
    idx_d  = idx_q;
    oval_d = oval_q;
    out_d  = out_q;
    if (load) begin
      oval_d = 1'b0;
      if (busy_q) begin
        oval_d         = 1'b1;
        out_d.out_byte = word_q[8*idx_q +: 8];
        out_d.last     = (idx_q == 3'd0);
        if (idx_q == 3'd0) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q - 3'd1;
        end
      end else if (!stat_i.empty) begin
        oval_d = 1'b1;
        if (job_i.is_single) begin
          out_d.out_byte = job_i.word[7:0];
          out_d.last     = 1'b1;
        end else begin
          out_d.out_byte = 8'(gve_pkg::CNT_BASE - 9'(job_i.nbytes));
          out_d.last     = 1'b0;
          busy_d         = 1'b1;
          word_d         = job_i.word;
          idx_d          = 3'(job_i.nbytes - 4'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      oval_q <= oval_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  assign out_valid_o = oval_q;
  assign out_o       = out_q;

endmodule

// File: hdl/gob_style_varint_encoder.sv
// Gob-style varint encoder. Each request carries a 64-bit value and its kind
// (unsigned, signed, double bit pattern); the block maps it to an unsigned word
// and emits it as a byte stream: a single byte for words up to 0x7f, otherwise
// a count byte (256 minus the data length) followed by 1 to 8 data bytes, most
// significant first, with last set on the final byte. A value therefore takes
// 1 to 9 bytes of the output link, one byte per cycle while the receiver is ready;
// the back end serialiser sets that rate. Requests are classified combinationally
// on entry and held in a two-entry queue, so a new request is taken in any cycle
// the queue has room; the back end pops the head once its serialiser is free.
module gob_style_varint_encoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gve_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gve_pkg::out_t out_o
);

  gve_pkg::job_t   front_job;
  gve_pkg::job_t   head_job;
  gve_pkg::qstat_t qstat;
  logic            push;
  logic            pop;

  assign in_ready_o = !qstat.full;
  assign push       = in_valid_i && !qstat.full;

  gve_front u_front (
    .in_i  (in_i),
    .job_o (front_job)
  );

  gve_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (qstat)
  );

  gve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Kind code that the encoder must treat as unsigned
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 350;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_LEN     = 400;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 30;
  localparam int MAX_REPORTS  = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic          req_valid = 1'b0;
  logic          req_ready;
  gve_pkg::in_t  req_data  = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  gve_pkg::out_t rsp_data;

  gve_pkg::in_t  pending_reqs[$];
  gve_pkg::out_t expected_bytes[$];

  int reqs_sent    = 0;
  int bytes_taken  = 0;
  int send_gap     = 0;
  int rcv_wait     = 0;
  int hold_left    = 0;
  logic hold_fired = 1'b0;
  int quiet_cycles = 0;
  int fail_count   = 0;

  gob_style_varint_encoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_i        (req_data),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_o       (rsp_data)
  );

  always #10 clk = ~clk;

  // Map a request to its word and append the bytes it should produce
  function automatic void encode_value(input gve_pkg::in_t req);
    logic [63:0]   v;
    logic [63:0]   word;
    logic [8:0]    cnt;
    int            nbytes;
    gve_pkg::out_t b;
    v    = req.value;
    word = v;
    case (req.operation)
      gve_pkg::OP_SIGNED: word = v[63] ? {~v[62:0], 1'b1} : {v[62:0], 1'b0};
      gve_pkg::OP_DOUBLE: begin
        for (int k = 0; k < 8; k++) word[8*k +: 8] = v[8*(7-k) +: 8];
      end
      default: word = v;
    endcase
    nbytes = 0;
    for (int k = 0; k < 8; k++) begin
      if (word[8*k +: 8] != 8'd0) nbytes = k + 1;
    end
    if (word <= gve_pkg::SMALL_MAX) begin
      b.out_byte = word[7:0];
      b.last     = 1'b1;
      expected_bytes.push_back(b);
    end else begin
      cnt        = gve_pkg::CNT_BASE - 9'(nbytes);
      b.out_byte = cnt[7:0];
      b.last     = 1'b0;
      expected_bytes.push_back(b);
      for (int k = nbytes - 1; k >= 0; k--) begin
        b.out_byte = word[8*k +: 8];
        b.last     = (k == 0);
        expected_bytes.push_back(b);
      end
    end
  endfunction

  task automatic queue_request(input logic [1:0] op, input logic [63:0] value);
    gve_pkg::in_t r;
    r.operation = op;
    r.value     = value;
    pending_reqs.push_back(r);
  endtask

  task automatic report_fault(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Driver: offer pending requests, idling a drawn number of cycles before each
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = req_valid;
    if (rst_n) begin
      if (req_valid && req_ready) begin
        nxt_valid = 1'b0;
        reqs_sent <= reqs_sent + 1;
        send_gap = ((reqs_sent / 32) % 3 == 2) ? 0 : $urandom_range(0, 9);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          req_data <= pending_reqs.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    req_valid <= nxt_valid;
  end

  // Long receiver hold-off, once, so the encoder fills up and stalls its input
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_fired && reqs_sent == HOLD_AT) begin
        hold_left  <= HOLD_LEN;
        hold_fired <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted byte
  always @(posedge clk) begin
    gve_pkg::out_t want;
    logic          nxt_ready;
    if (rst_n) begin
      if (req_valid && req_ready) encode_value(req_data);
      if (rsp_valid && rsp_ready) begin
        bytes_taken++;
        if (expected_bytes.size() == 0) begin
          report_fault($sformatf("unexpected byte %02h last %0b",
                                 rsp_data.out_byte, rsp_data.last));
        end else begin
          want = expected_bytes.pop_front();
          if (rsp_data.out_byte !== want.out_byte || rsp_data.last !== want.last)
            report_fault($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                   bytes_taken, want.out_byte, want.last,
                                   rsp_data.out_byte, rsp_data.last));
        end
        rcv_wait = ((bytes_taken / 64) % 3 == 1) ? 0 : $urandom_range(0, 9);
      end
      nxt_ready = 1'b1;
      if (rcv_wait > 0) begin
        rcv_wait--;
        nxt_ready = 1'b0;
      end
      rsp_ready <= nxt_ready && (hold_left == 0);
    end
  end

  // Watchdog: end the run if neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("gob_style_varint_encoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] raw;
    logic [63:0] lo_mask;
    logic [63:0] hi_mask;
    logic [63:0] v;
    logic [1:0]  op;
    int          span;
    int          pick;

    // Unsigned: single-byte limit, first and last length boundaries, full width
    queue_request(gve_pkg::OP_UNSIGNED, 64'h0);
    queue_request(gve_pkg::OP_UNSIGNED, 64'h7f);
    queue_request(gve_pkg::OP_UNSIGNED, 64'h80);
    queue_request(gve_pkg::OP_UNSIGNED, 64'hff);
    queue_request(gve_pkg::OP_UNSIGNED, 64'h100);
    queue_request(gve_pkg::OP_UNSIGNED, 64'h0100_0000_0000_0000);
    queue_request(gve_pkg::OP_UNSIGNED, 64'hffff_ffff_ffff_ffff);
    // Signed: zero, small either side, length boundary, overflow at the top
    queue_request(gve_pkg::OP_SIGNED, 64'h0);
    queue_request(gve_pkg::OP_SIGNED, 64'hffff_ffff_ffff_ffff);
    queue_request(gve_pkg::OP_SIGNED, 64'h3f);
    queue_request(gve_pkg::OP_SIGNED, 64'h40);
    queue_request(gve_pkg::OP_SIGNED, 64'hffff_ffff_ffff_ffc0);
    queue_request(gve_pkg::OP_SIGNED, 64'hffff_ffff_ffff_ffbf);
    queue_request(gve_pkg::OP_SIGNED, 64'h7fff_ffff_ffff_ffff);
    queue_request(gve_pkg::OP_SIGNED, 64'h8000_0000_0000_0000);
    queue_request(gve_pkg::OP_SIGNED, 64'hc000_0000_0000_0001);
    // Double bit patterns: zero, one point zero, small after reversal, long
    queue_request(gve_pkg::OP_DOUBLE, 64'h0);
    queue_request(gve_pkg::OP_DOUBLE, 64'h3ff0_0000_0000_0000);
    queue_request(gve_pkg::OP_DOUBLE, 64'h7f00_0000_0000_0000);
    queue_request(gve_pkg::OP_DOUBLE, 64'h8000_0000_0000_0000);
    queue_request(gve_pkg::OP_DOUBLE, 64'h0000_0000_0000_00ff);
    queue_request(gve_pkg::OP_DOUBLE, 64'hffff_ffff_ffff_ffff);
    // Unused kind behaves as unsigned
    queue_request(OP_SPARE, 64'h5);
    queue_request(OP_SPARE, 64'h7f);
    queue_request(OP_SPARE, 64'hdead_beef_1234_5678);

    // Random requests spread over every encoded length
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 15);
      if (pick < 5)       op = gve_pkg::OP_UNSIGNED;
      else if (pick < 10) op = gve_pkg::OP_SIGNED;
      else if (pick < 15) op = gve_pkg::OP_DOUBLE;
      else                op = OP_SPARE;
      span    = $urandom_range(0, 8);
      raw     = {$urandom, $urandom};
      lo_mask = ~(64'hffff_ffff_ffff_ffff << (8 * span));
      hi_mask = ~(64'hffff_ffff_ffff_ffff >> (8 * span));
      if (op == gve_pkg::OP_SIGNED) begin
        v = raw & lo_mask;
        if ($urandom_range(0, 1)) v = ~v;
      end else if ($urandom_range(0, 1)) begin
        v = raw & hi_mask;
      end else begin
        v = raw & lo_mask;
      end
      queue_request(op, v);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: wait until every request is taken and every byte seen
    @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("gob_style_varint_encoder regression: pass");
    end else begin
      $display("gob_style_varint_encoder regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/gve_pkg.sv
hdl/gve_front.sv
hdl/gve_queue.sv
hdl/gve_back.sv
hdl/gob_style_varint_encoder.sv
tb/sv/tb_top.sv
